>>> rtl/ftue_pkg.sv
`default_nettype none

package ftue_pkg;

   // Fixed field widths of the ports
   localparam int IN_BITS  = 21;
   localparam int OUT_BITS = 20;

   // Result kinds
   localparam logic [1:0] KIND_TRI  = 2'd0;
   localparam logic [1:0] KIND_EDGE = 2'd1;
   localparam logic [1:0] KIND_FULL = 2'd2;

   // Sequencer to scanner
   typedef struct packed {
      logic start;
      logic insert;
   } scan_ctl_type;

   // Scanner to sequencer
   typedef struct packed {
      logic done;
      logic found;
      logic full;
   } scan_sts_type;

endpackage

`default_nettype wire

>>> rtl/ftue_ram.sv
`default_nettype none

module ftue_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into a register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/ftue_scan.sv
`default_nettype none

module ftue_scan #(
   parameter int MAX_EDGES  = 256,
   parameter int INDEX_BITS = 20
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ftue_pkg::scan_ctl_type    ctl,
   input  wire logic [INDEX_BITS-1:0]     probe_lo,
   input  wire logic [INDEX_BITS-1:0]     probe_hi,
   output ftue_pkg::scan_sts_type         sts
);

   localparam int AW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int DW = 2 * INDEX_BITS;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          active_ff, active_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          done_ff, done_in;
   logic          found_ff, found_in;
   logic          issue;
   logic          match;
   logic          full;
   logic [DW-1:0] rd_data;
   logic [DW-1:0] probe;

   assign probe = {probe_hi, probe_lo};
   assign full  = (count_ff == CW'(MAX_EDGES));
   assign issue = active_ff && (scan_idx_ff != count_ff);

   // Shared compare unit: one stored edge against the probe per cycle
   assign match = active_ff && rd_vld_ff && (rd_data == probe);

   ftue_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_EDGES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.insert),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (probe),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Advance the scan, stop on a hit or past the last stored edge, and count inserted edges
   always_comb begin
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      active_in   = active_ff;
      rd_vld_in   = issue;
      done_in     = 1'b0;
      found_in    = 1'b0;
      if (ctl.start) begin
         scan_idx_in = '0;
         active_in   = 1'b1;
         rd_vld_in   = 1'b0;
      end else if (active_ff) begin
         if (issue) begin
            scan_idx_in = scan_idx_ff + CW'(1);
         end
         if (match) begin
            active_in = 1'b0;
            done_in   = 1'b1;
            found_in  = 1'b1;
         end else if (!issue && !rd_vld_ff) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
      if (ctl.insert) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         active_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         active_ff <= active_in;
         rd_vld_ff <= rd_vld_in;
         done_ff   <= done_in;
         found_ff  <= found_in;
      end
      scan_idx_ff <= scan_idx_in;
   end

   assign sts.done  = done_ff;
   assign sts.found = found_ff;
   assign sts.full  = full;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EDGES))
      else $error("edge count past table size");

   a_insert_ok: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |-> !active_ff && !full)
      else $error("insert during scan or into full table");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> active_ff && !done_ff)
      else $error("scan did not start");

endmodule

`default_nettype wire

>>> rtl/fan_triangulate_unique_edges.sv
`default_nettype none

// Fan triangulation with unique edge extraction.
//
// Input: one polygon corner per transfer (req_vertex_index, one-based, and
// req_face_end on the last corner of a face), taken when start is high and
// busy is low. Results leave on rsp_* for exactly one cycle each, marked by
// rsp_valid; rsp_last flags the final result of an input item. The receiver
// cannot stall the block.
// The first two corners of a face produce no result and are taken while
// busy stays low. Each later corner emits a triangle followed by its new
// edges (kind 1) or edges dropped on a full table (kind 2). The triangle's edges
// are checked one after another by a scan of the edge memory through its
// single read port, one entry per cycle, with one equality comparator.
// Each check reads the stored edges in order and ends early on a hit;
// busy stays high through the three checks and the flush state. The
// triangle is held back and leaves when the next result is ready or at
// the flush; the final result is on the ports in the first cycle with
// busy low again.
// Reset (synchronous) empties the edge table and starts a new face; the edge
// memory itself is not cleared, since only entries below the count are read.

module fan_triangulate_unique_edges #(
   parameter int MAX_EDGES  = 256,
   parameter int INDEX_BITS = 20
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [ftue_pkg::IN_BITS-1:0]     req_vertex_index,
   input  wire logic                             req_face_end,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_kind,
   output logic [ftue_pkg::OUT_BITS-1:0]         rsp_index_a,
   output logic [ftue_pkg::OUT_BITS-1:0]         rsp_index_b,
   output logic [ftue_pkg::OUT_BITS-1:0]         rsp_index_c,
   output logic                                  rsp_last
);

   localparam int IB = INDEX_BITS;
   localparam int RW = (IB > ftue_pkg::IN_BITS) ? IB : ftue_pkg::IN_BITS;
   localparam int XW = (IB > ftue_pkg::OUT_BITS) ? IB : ftue_pkg::OUT_BITS;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOAD  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   localparam logic [1:0] EDGE_LAST = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [1:0]    corners_ff, corners_in;
   logic [IB-1:0] anchor_ff, anchor_in;
   logic [IB-1:0] prev_ff, prev_in;
   logic [IB-1:0] tri_a_ff, tri_a_in;
   logic [IB-1:0] tri_b_ff, tri_b_in;
   logic [IB-1:0] tri_c_ff, tri_c_in;
   logic [1:0]    edge_sel_ff, edge_sel_in;
   logic [IB-1:0] probe_lo_ff, probe_lo_in;
   logic [IB-1:0] probe_hi_ff, probe_hi_in;
   logic [1:0]    pend_kind_ff, pend_kind_in;
   logic [IB-1:0] pend_a_ff, pend_a_in;
   logic [IB-1:0] pend_b_ff, pend_b_in;
   logic [IB-1:0] pend_c_ff, pend_c_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic [1:0]                    rsp_kind_ff, rsp_kind_in;
   logic [ftue_pkg::OUT_BITS-1:0] rsp_a_ff, rsp_a_in;
   logic [ftue_pkg::OUT_BITS-1:0] rsp_b_ff, rsp_b_in;
   logic [ftue_pkg::OUT_BITS-1:0] rsp_c_ff, rsp_c_in;

   logic          accept;
   logic [RW-1:0] raw_ext, raw_dec;
   logic [IB-1:0] cur;
   logic [IB-1:0] end_x, end_y, end_lo, end_hi;
   logic [XW-1:0] pend_a_x, pend_b_x, pend_c_x;
   logic          emit, emit_last;

   ftue_pkg::scan_ctl_type scan_ctl;
   ftue_pkg::scan_sts_type scan_sts;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Convert to zero-based, wrapping at the index width
   assign raw_ext = RW'(req_vertex_index);
   assign raw_dec = raw_ext - RW'(1);
   assign cur     = raw_dec[IB-1:0];

   // Pick the ends of the current triangle edge
   always_comb begin
      unique case (edge_sel_ff)
         2'd0: begin
            end_x = tri_a_ff;
            end_y = tri_b_ff;
         end
         2'd1: begin
            end_x = tri_b_ff;
            end_y = tri_c_ff;
         end
         2'd2: begin
            end_x = tri_c_ff;
            end_y = tri_a_ff;
         end
         default: begin
            end_x = tri_a_ff;
            end_y = tri_b_ff;
         end
      endcase
   end

   // Order the edge as (min, max)
   assign end_lo = (end_x < end_y) ? end_x : end_y;
   assign end_hi = (end_x < end_y) ? end_y : end_x;

   // Fit the held result to the output width
   assign pend_a_x = XW'(pend_a_ff);
   assign pend_b_x = XW'(pend_b_ff);
   assign pend_c_x = XW'(pend_c_ff);

   // Sequencer: hold one result back so the final one can carry last
   always_comb begin
      state_in     = state_ff;
      corners_in   = corners_ff;
      anchor_in    = anchor_ff;
      prev_in      = prev_ff;
      tri_a_in     = tri_a_ff;
      tri_b_in     = tri_b_ff;
      tri_c_in     = tri_c_ff;
      edge_sel_in  = edge_sel_ff;
      probe_lo_in  = probe_lo_ff;
      probe_hi_in  = probe_hi_ff;
      pend_kind_in = pend_kind_ff;
      pend_a_in    = pend_a_ff;
      pend_b_in    = pend_b_ff;
      pend_c_in    = pend_c_ff;
      scan_ctl     = '0;
      emit         = 1'b0;
      emit_last    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (corners_ff == 2'd0) begin
                  anchor_in  = cur;
                  corners_in = 2'd1;
               end else if (corners_ff == 2'd1) begin
                  prev_in    = cur;
                  corners_in = 2'd2;
               end else begin
                  tri_a_in     = anchor_ff;
                  tri_b_in     = prev_ff;
                  tri_c_in     = cur;
                  prev_in      = cur;
                  pend_kind_in = ftue_pkg::KIND_TRI;
                  pend_a_in    = anchor_ff;
                  pend_b_in    = prev_ff;
                  pend_c_in    = cur;
                  edge_sel_in  = 2'd0;
                  state_in     = S_LOAD;
               end
               if (req_face_end) begin
                  corners_in = 2'd0;
               end
            end
         end
         S_LOAD: begin
            probe_lo_in    = end_lo;
            probe_hi_in    = end_hi;
            scan_ctl.start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            if (scan_sts.done) begin
               if (!scan_sts.found) begin
                  emit            = 1'b1;
                  pend_kind_in    = scan_sts.full ? ftue_pkg::KIND_FULL
                                                  : ftue_pkg::KIND_EDGE;
                  pend_a_in       = probe_lo_ff;
                  pend_b_in       = probe_hi_ff;
                  pend_c_in       = '0;
                  scan_ctl.insert = !scan_sts.full;
               end
               if (edge_sel_ff == EDGE_LAST) begin
                  state_in = S_FLUSH;
               end else begin
                  edge_sel_in = edge_sel_ff + 2'd1;
                  state_in    = S_LOAD;
               end
            end
         end
         S_FLUSH: begin
            emit      = 1'b1;
            emit_last = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Register the outgoing transfer
   assign rsp_valid_in = emit;
   assign rsp_last_in  = emit_last;
   assign rsp_kind_in  = pend_kind_ff;
   assign rsp_a_in     = pend_a_x[ftue_pkg::OUT_BITS-1:0];
   assign rsp_b_in     = pend_b_x[ftue_pkg::OUT_BITS-1:0];
   assign rsp_c_in     = pend_c_x[ftue_pkg::OUT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         corners_ff   <= 2'd0;
         anchor_ff    <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corners_ff   <= corners_in;
         anchor_ff    <= anchor_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tri_a_ff     <= tri_a_in;
      tri_b_ff     <= tri_b_in;
      tri_c_ff     <= tri_c_in;
      edge_sel_ff  <= edge_sel_in;
      probe_lo_ff  <= probe_lo_in;
      probe_hi_ff  <= probe_hi_in;
      pend_kind_ff <= pend_kind_in;
      pend_a_ff    <= pend_a_in;
      pend_b_ff    <= pend_b_in;
      pend_c_ff    <= pend_c_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_c_ff     <= rsp_c_in;
   end

   ftue_scan #(
      .MAX_EDGES  (MAX_EDGES),
      .INDEX_BITS (INDEX_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .probe_lo (probe_lo_ff),
      .probe_hi (probe_hi_ff),
      .sts      (scan_sts)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_index_a = rsp_a_ff;
   assign rsp_index_b = rsp_b_ff;
   assign rsp_index_c = rsp_c_ff;

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy after final result");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_sts.done |-> state_ff == S_SCAN)
      else $error("scan finished outside scan state");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      emit && state_ff == S_SCAN |=> !rsp_last)
      else $error("edge result flagged last");

endmodule

`default_nettype wire

>>> tb/fan_edge_checker.sv
`timescale 1ns / 100ps

module fan_edge_checker #(
   parameter int MAX_EDGES  = 256,
   parameter int INDEX_BITS = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic [ftue_pkg::IN_BITS-1:0] req_vertex_index,
   input  wire logic                         req_face_end,
   input  wire logic                         rsp_valid,
   input  wire logic [1:0]                   rsp_kind,
   input  wire logic [ftue_pkg::OUT_BITS-1:0] rsp_index_a,
   input  wire logic [ftue_pkg::OUT_BITS-1:0] rsp_index_b,
   input  wire logic [ftue_pkg::OUT_BITS-1:0] rsp_index_c,
   input  wire logic                         rsp_last,
   output int                                fail_count,
   output int                                results_waiting,
   output int                                triangle_count,
   output int                                stored_edge_count,
   output int                                dropped_edge_count
);

   localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);
   localparam int          REPORT_LIMIT = 10;

   typedef struct packed {
      logic [1:0]                    kind;
      logic [ftue_pkg::OUT_BITS-1:0] a;
      logic [ftue_pkg::OUT_BITS-1:0] b;
      logic [ftue_pkg::OUT_BITS-1:0] c;
      logic                          last;
   } fan_result_type;

   // Shadow of the fan state and the unique edge table
   logic [31:0] fan_anchor;
   logic [31:0] prior_corner;
   int          face_corners;
   logic [31:0] table_lo [MAX_EDGES];
   logic [31:0] table_hi [MAX_EDGES];
   int          table_fill;

   fan_result_type pending_results [$];

   function automatic fan_result_type make_result(input logic [1:0] kind,
                                                  input logic [31:0] a,
                                                  input logic [31:0] b,
                                                  input logic [31:0] c);
      fan_result_type r;
      r.kind = kind;
      r.a    = a[ftue_pkg::OUT_BITS-1:0];
      r.b    = b[ftue_pkg::OUT_BITS-1:0];
      r.c    = c[ftue_pkg::OUT_BITS-1:0];
      r.last = 1'b0;
      return r;
   endfunction

   // Order one edge, look it up, and append it when new and there is room
   task automatic classify_edge(input logic [31:0] x, input logic [31:0] y,
                                output logic emit, output fan_result_type r);
      logic [31:0] lo;
      logic [31:0] hi;
      int          i;
      lo   = (x < y) ? x : y;
      hi   = (x < y) ? y : x;
      emit = 1'b1;
      for (i = 0; i < table_fill; i++)
         if (table_lo[i] == lo && table_hi[i] == hi) emit = 1'b0;
      r = make_result(ftue_pkg::KIND_EDGE, lo, hi, 32'd0);
      if (emit) begin
         if (table_fill >= MAX_EDGES) begin
            r.kind = ftue_pkg::KIND_FULL;
            dropped_edge_count++;
         end else begin
            table_lo[table_fill] = lo;
            table_hi[table_fill] = hi;
            table_fill++;
            stored_edge_count++;
         end
      end
   endtask

   // Advance the fan by one corner and queue the results it causes
   task automatic predict_corner(input logic [ftue_pkg::IN_BITS-1:0] raw,
                                 input logic face_end);
      logic [31:0]    cur;
      fan_result_type batch [4];
      fan_result_type r;
      logic           emit;
      int             n;
      int             i;
      cur = ({11'd0, raw} - 32'd1) & IDX_MASK;
      n   = 0;
      if (face_corners == 0) begin
         fan_anchor   = cur;
         face_corners = 1;
      end else if (face_corners == 1) begin
         prior_corner = cur;
         face_corners = 2;
      end else begin
         batch[0] = make_result(ftue_pkg::KIND_TRI, fan_anchor, prior_corner, cur);
         n = 1;
         triangle_count++;
         classify_edge(fan_anchor, prior_corner, emit, r);
         if (emit) begin
            batch[n] = r;
            n++;
         end
         classify_edge(prior_corner, cur, emit, r);
         if (emit) begin
            batch[n] = r;
            n++;
         end
         classify_edge(cur, fan_anchor, emit, r);
         if (emit) begin
            batch[n] = r;
            n++;
         end
         prior_corner = cur;
      end
      if (face_end) face_corners = 0;
      for (i = 0; i < n; i++) begin
         r      = batch[i];
         r.last = (i == n - 1);
         pending_results = {pending_results, r};
      end
   endtask

   // Match one result transfer against the oldest expectation
   task automatic check_result();
      fan_result_type got;
      fan_result_type want;
      got.kind = rsp_kind;
      got.a    = rsp_index_a;
      got.b    = rsp_index_b;
      got.c    = rsp_index_c;
      got.last = rsp_last;
      if (pending_results.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected result kind=%0d a=%h b=%h c=%h last=%b",
                     $realtime, got.kind, got.a, got.b, got.c, got.last);
      end else begin
         want = pending_results.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display({"%0t: mismatch expected kind=%0d a=%h b=%h c=%h last=%b,",
                         " got kind=%0d a=%h b=%h c=%h last=%b"},
                        $realtime, want.kind, want.a, want.b, want.c, want.last,
                        got.kind, got.a, got.b, got.c, got.last);
         end
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         fan_anchor         = '0;
         prior_corner       = '0;
         face_corners       = 0;
         table_fill         = 0;
         fail_count         = 0;
         triangle_count     = 0;
         stored_edge_count  = 0;
         dropped_edge_count = 0;
         pending_results.delete();
      end else begin
         if (start && !busy) predict_corner(req_vertex_index, req_face_end);
         if (rsp_valid) check_result();
      end
      results_waiting <= pending_results.size();
   end

endmodule

>>> tb/fan_triangulate_unique_edges_tb.sv
`timescale 1ns / 100ps

module fan_triangulate_unique_edges_tb;

   localparam int EDGE_SLOTS = 256;
   localparam int IDX_BITS   = 20;
   localparam int DIR_N      = 20;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [ftue_pkg::IN_BITS-1:0]  req_vertex_index;
   logic                          req_face_end;
   logic                          rsp_valid;
   logic [1:0]                    rsp_kind;
   logic [ftue_pkg::OUT_BITS-1:0] rsp_index_a;
   logic [ftue_pkg::OUT_BITS-1:0] rsp_index_b;
   logic [ftue_pkg::OUT_BITS-1:0] rsp_index_c;
   logic                          rsp_last;

   int fail_count;
   int results_waiting;
   int triangle_count;
   int stored_edge_count;
   int dropped_edge_count;
   int sender_idle_pct;
   int corners_sent;

   // Directed faces: basic fan, shared edge, index extremes, short faces, degenerate
   logic [ftue_pkg::IN_BITS-1:0] dir_vertex [DIR_N] = '{
      21'd1, 21'd2, 21'd3,
      21'd1, 21'd3, 21'd4, 21'd5,
      21'd0, 21'h1FFFFF, 21'h100000, 21'h100001,
      21'd9,
      21'd10, 21'd11,
      21'd7, 21'd7, 21'd7,
      21'd8, 21'd6, 21'd7
   };
   logic dir_end [DIR_N] = '{
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b1,
      1'b1,
      1'b0, 1'b1,
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b1
   };

   initial clock = 1'b0;
   always #4 clock = ~clock;

   fan_triangulate_unique_edges #(
      .MAX_EDGES  (EDGE_SLOTS),
      .INDEX_BITS (IDX_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_vertex_index (req_vertex_index),
      .req_face_end     (req_face_end),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_index_a      (rsp_index_a),
      .rsp_index_b      (rsp_index_b),
      .rsp_index_c      (rsp_index_c),
      .rsp_last         (rsp_last)
   );

   fan_edge_checker #(
      .MAX_EDGES  (EDGE_SLOTS),
      .INDEX_BITS (IDX_BITS)
   ) edge_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_vertex_index   (req_vertex_index),
      .req_face_end       (req_face_end),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_index_a        (rsp_index_a),
      .rsp_index_b        (rsp_index_b),
      .rsp_index_c        (rsp_index_c),
      .rsp_last           (rsp_last),
      .fail_count         (fail_count),
      .results_waiting    (results_waiting),
      .triangle_count     (triangle_count),
      .stored_edge_count  (stored_edge_count),
      .dropped_edge_count (dropped_edge_count)
   );

   // Hold start low, with noise on the data
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start            <= 1'b0;
         req_vertex_index <= ftue_pkg::IN_BITS'($urandom);
         req_face_end     <= 1'($urandom);
      end
   endtask

   // Present one corner and return after its transfer
   task automatic send_corner(input logic [ftue_pkg::IN_BITS-1:0] raw, input logic face_end);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
         idle_cycles($urandom_range(8, 1));
      @(negedge clock);
      start            <= 1'b1;
      req_vertex_index <= raw;
      req_face_end     <= face_end;
      @(posedge clock);
      while (busy) @(posedge clock);
      corners_sent++;
   endtask

   // Hold off until every expected result has come
   task automatic drain();
      idle_cycles(1);
      wait (results_waiting == 0);
   endtask

   // Mostly well-formed faces from a small, medium or full index range;
   // some faces end after one or two corners
   task automatic send_random_face(output int tri_items);
      int                           corners;
      int                           span;
      int                           k;
      logic [ftue_pkg::IN_BITS-1:0] v;
      corners   = ($urandom_range(99) < 12) ? $urandom_range(2, 1) : $urandom_range(7, 3);
      span      = $urandom_range(99);
      tri_items = (corners > 2) ? corners - 2 : 0;
      for (k = 0; k < corners; k++) begin
         if (span < 50)      v = ftue_pkg::IN_BITS'($urandom_range(24, 1));
         else if (span < 85) v = ftue_pkg::IN_BITS'($urandom_range(2000, 1));
         else                v = ftue_pkg::IN_BITS'($urandom);
         send_corner(v, k == corners - 1);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int tri_target);
      int done;
      int t;
      sender_idle_pct = idle_pct;
      done = 0;
      while (done < tri_target) begin
         send_random_face(t);
         done += t;
      end
      drain();
   endtask

   initial begin
      int i;
      reset            = 1'b1;
      start            = 1'b0;
      req_vertex_index = '0;
      req_face_end     = 1'b0;
      sender_idle_pct  = 0;
      corners_sent     = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_N; i++) send_corner(dir_vertex[i], dir_end[i]);
      drain();

      run_phase(21, 45);
      run_phase(66, 35);
      run_phase(0, 35);

      repeat (16) @(posedge clock);
      $display("Covered %0d corners: %0d triangles, %0d stored edges,",
               corners_sent, triangle_count, stored_edge_count);
      $display("%0d edges dropped on a full table; sender idled at 21, 66 and 0 percent",
               dropped_edge_count);
      if (fail_count == 0 && results_waiting == 0) begin
         $display("** fan_triangulate_unique_edges: PASSED **");
      end else begin
         $display("** fan_triangulate_unique_edges: FAILED **");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #12_000_000;
      $display("** fan_triangulate_unique_edges: FAILED **");
      $finish;
   end

endmodule
